/* design/bpc_pkg.sv */
// Shared types and constants of the bucketed position cache.
package bpc_pkg;

    // Width of the mate-window arithmetic, wide enough for score, mate and ply.
    localparam int ADJ_W = 26;
    localparam logic signed [ADJ_W-1:0] MATE_WINDOW = 26'sd1000;
    localparam logic signed [ADJ_W-1:0] SCORE_MAX = 26'sd8388607;
    localparam logic signed [ADJ_W-1:0] SCORE_MIN = -26'sd8388608;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 23;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_PROBE = 2'd0,
        REQ_STORE = 2'd1,
        REQ_CLEAR = 2'd2
    } req_code_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATE_SCORE  = 1'b0,
        CFG_CURRENT_AGE = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // One request transaction.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [23:0] score;
        logic signed [15:0] depth;
        logic [1:0]         bound_flag;
        logic [7:0]         ply;
    } req_t;

    // One response transaction.
    typedef struct packed {
        logic               hit;
        logic               written;
        logic [15:0]        out_move;
        logic signed [23:0] out_score;
        logic signed [15:0] out_depth;
        logic [1:0]         out_flag;
        logic [7:0]         out_age;
        logic [31:0]        hit_count;
        logic [31:0]        miss_count;
        logic [31:0]        store_count;
    } rsp_t;

    // One way of a bucket.
    typedef struct packed {
        logic [31:0]        tag;
        logic [15:0]        move;
        logic signed [23:0] score;
        logic signed [15:0] depth;
        logic [1:0]         flag;
        logic [7:0]         age;
    } entry_t;

    // Outcome of the way compare.
    typedef struct packed {
        logic hit;
        logic write_en;
    } sel_t;

endpackage

/* design/bpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bpc_bucket_unit.sv */
// Key-to-bucket reduction: a mask for power-of-two bucket counts, otherwise
// a serial remainder that folds four key bits per cycle.
module bpc_bucket_unit #(
    parameter int BUCKET_COUNT = 1024
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      start,
    input  logic [63:0]                                               key,
    output logic                                                      done,
    output logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] bucket
);

    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam bit IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;
            logic [BW-1:0] bucket_next;

            // A power-of-two count takes the low key bits; a single bucket is zero.
            always_comb
            begin
                if (BUCKET_COUNT == 1)
                begin
                    bucket_next = '0;
                end
                else
                begin
                    bucket_next = key[BW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg   <= 1'b0;
                    bucket_reg <= '0;
                end
                else
                begin
                    done_reg <= start;
                    if (start)
                    begin
                        bucket_reg <= bucket_next;
                    end
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else
        begin : g_serial
            localparam int STEP_BITS = 4;
            localparam int STEPS = 64 / STEP_BITS;
            localparam int CW = $clog2(STEPS);
            localparam logic [BW:0] MODULUS = (BW + 1)'(BUCKET_COUNT);

            logic          busy_reg, busy_next;
            logic          done_reg, done_next;
            logic [CW-1:0] cnt_reg, cnt_next;
            logic [63:0]   key_reg, key_next;
            logic [BW-1:0] rem_reg, rem_next;
            logic [BW-1:0] rem_step;
            logic [BW:0]   trial;

            // Four dependent shift-and-subtract steps on the running remainder.
            always_comb
            begin
                rem_step = rem_reg;
                trial    = '0;
                for (int i = 0; i < STEP_BITS; i++)
                begin
                    trial = {rem_step, key_reg[63 - i]};
                    if (trial >= MODULUS)
                    begin
                        trial = trial - MODULUS;
                    end
                    rem_step = trial[BW-1:0];
                end
            end

            // Step counter and operand shift.
            always_comb
            begin
                busy_next = busy_reg;
                done_next = 1'b0;
                cnt_next  = cnt_reg;
                key_next  = key_reg;
                rem_next  = rem_reg;
                if (start)
                begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    key_next  = key;
                    rem_next  = '0;
                end
                else if (busy_reg)
                begin
                    rem_next = rem_step;
                    key_next = {key_reg[63-STEP_BITS:0], {STEP_BITS{1'b0}}};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                    rem_reg  <= rem_next;
                end
            end

            always_ff @(posedge clk)
            begin
                key_reg <= key_next;
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

/* design/bpc_way_select.sv */
// Parallel way compare of one bucket: probe hit search, store victim choice
// and the merged row to write back.
module bpc_way_select #(
    parameter int WAYS = 4
) (
    input  bpc_pkg::entry_t [WAYS-1:0] row,
    input  logic [31:0]                tag,
    input  bpc_pkg::entry_t            new_entry,
    input  logic [7:0]                 current_age,
    output bpc_pkg::sel_t              sel,
    output bpc_pkg::entry_t            hit_entry,
    output bpc_pkg::entry_t [WAYS-1:0] wr_row
);

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic               hit_found;
    logic               qual_found;
    logic               min_valid;
    logic signed [15:0] min_depth;
    logic [WW-1:0]      qual_way;
    logic [WW-1:0]      shallow_way;
    logic [WW-1:0]      tgt_way;
    logic               write_en;

    // First way whose tag matches.
    always_comb
    begin
        hit_found = 1'b0;
        hit_entry = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!hit_found && row[i].tag == tag)
            begin
                hit_found = 1'b1;
                hit_entry = row[i];
            end
        end
    end

    // Victim: first matching, empty or stale way, else the first shallowest way
    // among the ways scanned before.
    always_comb
    begin
        qual_found  = 1'b0;
        qual_way    = '0;
        min_valid   = 1'b0;
        min_depth   = '0;
        shallow_way = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!qual_found)
            begin
                if (row[i].tag == tag || row[i].tag == '0 || row[i].age != current_age)
                begin
                    qual_found = 1'b1;
                    qual_way   = WW'(i);
                end
                else if (!min_valid || $signed(row[i].depth) < min_depth)
                begin
                    min_valid   = 1'b1;
                    min_depth   = row[i].depth;
                    shallow_way = WW'(i);
                end
            end
        end
        tgt_way  = qual_found ? qual_way : shallow_way;
        write_en = qual_found || ($signed(new_entry.depth) >= min_depth);
    end

    // Row with the victim way replaced.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            wr_row[i] = (write_en && tgt_way == WW'(i)) ? new_entry : row[i];
        end
    end

    assign sel.hit      = hit_found;
    assign sel.write_en = write_en;

endmodule

/* design/bucketed_position_cache.sv */
// Top level of the bucketed position cache: sequencer, counters and table.
//
// Requests arrive on req_valid/req_ready/req_data; each accepted transaction
// yields exactly one response on rsp_valid/rsp_ready/rsp_data. A probe returns
// the first way of its bucket whose tag matches; a store chooses a way and
// may write it; a clear wipes the table and the three counters.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are always
// taken, and must be issued only while no request is outstanding.
// A probe or store steps through the key reduction (ST_HASH), the bucket
// read (ST_READ) and the compare and write back (ST_DECIDE); the response is
// registered, and the next request is taken only once the sequencer is back
// in ST_IDLE. With a power-of-two BUCKET_COUNT the key reduction is a mask;
// otherwise it folds four key bits a cycle.
// A clear sweeps one bucket row per cycle over all BUCKET_COUNT rows, then
// answers from ST_FINISH. After reset the same sweep runs with req_ready low.
// The response sits in an output register; while the receiver stalls, a
// finished request waits in its last step and the table is not touched.
module bucketed_position_cache #(
    parameter int BUCKET_COUNT = 1024,
    parameter int WAYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  bpc_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output bpc_pkg::rsp_t                       rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ADDR_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int ROW_W = WAYS * $bits(bpc_pkg::entry_t);

    bpc_pkg::state_t state_reg, state_next;
    bpc_pkg::req_t   req_reg, req_next;
    bpc_pkg::rsp_t   rsp_data_reg, rsp_data_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic            clr_rsp_reg, clr_rsp_next;
    logic [31:0]     hits_reg, hits_next;
    logic [31:0]     misses_reg, misses_next;
    logic [31:0]     stores_reg, stores_next;
    logic [22:0]     mate_reg, mate_next;
    logic [7:0]      age_reg, age_next;
    logic signed [23:0] nscore_reg, nscore_next;

    logic            accept;
    logic            hash_start;
    logic            out_free;
    logic            rsp_load;
    logic            hash_done;
    logic [ADDR_W-1:0] bucket;
    logic            ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    bpc_pkg::entry_t [WAYS-1:0] rd_row;
    bpc_pkg::entry_t [WAYS-1:0] wr_row;
    bpc_pkg::entry_t new_entry;
    bpc_pkg::entry_t hit_entry;
    bpc_pkg::sel_t   sel;

    logic signed [bpc_pkg::ADJ_W-1:0] s_ext, mate_ext, ply_ext, adj;

    assign accept     = req_valid && req_ready;
    assign hash_start = accept && (req_data.req_type != bpc_pkg::REQ_CLEAR);
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == bpc_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // Key reduction unit, started on every accepted request that is not a clear.
    bpc_bucket_unit #(
        .BUCKET_COUNT(BUCKET_COUNT)
    ) u_bucket (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (req_data.key),
        .done   (hash_done),
        .bucket (bucket)
    );

    // Table: one row per bucket holding all its ways.
    bpc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(BUCKET_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (bucket),
        .rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    // Entry a store would write.
    always_comb
    begin
        new_entry.tag   = req_reg.key[63:32];
        new_entry.move  = req_reg.move;
        new_entry.score = nscore_reg;
        new_entry.depth = req_reg.depth;
        new_entry.flag  = req_reg.bound_flag;
        new_entry.age   = age_reg;
    end

    bpc_way_select #(
        .WAYS(WAYS)
    ) u_select (
        .row         (rd_row),
        .tag         (req_reg.key[63:32]),
        .new_entry   (new_entry),
        .current_age (age_reg),
        .sel         (sel),
        .hit_entry   (hit_entry),
        .wr_row      (wr_row)
    );

    // Mate-range adjustment by ply, then saturation to the score range.
    always_comb
    begin
        s_ext    = bpc_pkg::ADJ_W'(req_reg.score);
        mate_ext = $signed({3'b0, mate_reg});
        ply_ext  = $signed({18'b0, req_reg.ply});
        if (s_ext > mate_ext - bpc_pkg::MATE_WINDOW)
        begin
            adj = s_ext + ply_ext;
        end
        else if (s_ext < bpc_pkg::MATE_WINDOW - mate_ext)
        begin
            adj = s_ext - ply_ext;
        end
        else
        begin
            adj = s_ext;
        end
        if (adj > bpc_pkg::SCORE_MAX)
        begin
            nscore_next = bpc_pkg::SCORE_MAX[23:0];
        end
        else if (adj < bpc_pkg::SCORE_MIN)
        begin
            nscore_next = bpc_pkg::SCORE_MIN[23:0];
        end
        else
        begin
            nscore_next = adj[23:0];
        end
    end

    // Configuration register writes.
    always_comb
    begin
        mate_next = mate_reg;
        age_next  = age_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::CFG_MATE_SCORE:  mate_next = cfg_data[22:0];
                bpc_pkg::CFG_CURRENT_AGE: age_next = cfg_data[7:0];
            endcase
        end
    end

    // Sequencer: next state, counters, table writes and response loading.
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_rsp_next  = clr_rsp_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        stores_next   = stores_reg;
        rsp_load      = 1'b0;
        rsp_data_next = rsp_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = bucket;
        ram_wdata     = wr_row;

        unique case (state_reg)
            bpc_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(BUCKET_COUNT - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_rsp_reg ? bpc_pkg::ST_FINISH : bpc_pkg::ST_IDLE;
                end
            end
            bpc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    if (req_data.req_type == bpc_pkg::REQ_CLEAR)
                    begin
                        hits_next    = '0;
                        misses_next  = '0;
                        stores_next  = '0;
                        clr_cnt_next = '0;
                        clr_rsp_next = 1'b1;
                        state_next   = bpc_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = bpc_pkg::ST_HASH;
                    end
                end
            end
            bpc_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = bpc_pkg::ST_READ;
                end
            end
            bpc_pkg::ST_READ:
            begin
                state_next = bpc_pkg::ST_DECIDE;
            end
            bpc_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    rsp_load      = 1'b1;
                    rsp_data_next = '0;
                    unique case (req_reg.req_type)
                        bpc_pkg::REQ_PROBE:
                        begin
                            if (sel.hit)
                            begin
                                hits_next               = hits_reg + 1'b1;
                                rsp_data_next.hit       = 1'b1;
                                rsp_data_next.out_move  = hit_entry.move;
                                rsp_data_next.out_score = hit_entry.score;
                                rsp_data_next.out_depth = hit_entry.depth;
                                rsp_data_next.out_flag  = hit_entry.flag;
                                rsp_data_next.out_age   = hit_entry.age;
                            end
                            else
                            begin
                                misses_next = misses_reg + 1'b1;
                            end
                        end
                        bpc_pkg::REQ_STORE:
                        begin
                            if (sel.write_en)
                            begin
                                ram_we                = 1'b1;
                                stores_next           = stores_reg + 1'b1;
                                rsp_data_next.written = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_data_next.hit_count   = hits_next;
                    rsp_data_next.miss_count  = misses_next;
                    rsp_data_next.store_count = stores_next;
                    state_next = bpc_pkg::ST_IDLE;
                end
            end
            bpc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_load      = 1'b1;
                    rsp_data_next = '0;
                    clr_rsp_next  = 1'b0;
                    state_next    = bpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state and counters; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_rsp_reg   <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            stores_reg    <= '0;
            mate_reg      <= 23'd30000;
            age_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_rsp_reg   <= clr_rsp_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            stores_reg    <= stores_next;
            mate_reg      <= mate_next;
            age_reg       <= age_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (state_reg == bpc_pkg::ST_READ)
        begin
            nscore_reg <= nscore_next;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // A response is loaded only into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response loaded over a pending response");

    // The key reduction finishes only while the sequencer waits for it.
    a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == bpc_pkg::ST_HASH)
        else $error("bucket result arrived outside the hash step");

    // A written store bumps the store counter by exactly one.
    a_store_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && state_reg == bpc_pkg::ST_DECIDE && rsp_data_next.written)
        |=> stores_reg == $past(stores_reg) + 32'd1)
        else $error("store counter out of step with table writes");

    // No response reports both a probe hit and a store write.
    a_hit_or_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_data_reg.hit && rsp_data_reg.written))
        else $error("response flags both hit and written");

    // The table is written only while clearing or finishing a request.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == bpc_pkg::ST_CLEAR || state_reg == bpc_pkg::ST_DECIDE))
        else $error("table write outside clear or decide");

endmodule

/* dv/tb_bucketed_position_cache.sv */
// Self-checking testbench for the bucketed position cache: directed and random requests.
`timescale 1ns / 1ps

module tb_bucketed_position_cache;

    localparam int BUCKETS = 1024;
    localparam int WAYS = 4;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam longint MATE_SPAN = 1000;
    localparam longint SAT_HI = 8388607;
    localparam longint SAT_LO = -8388608;
    localparam int STALL_LIMIT = 8000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PHASES = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    bpc_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    bpc_pkg::rsp_t rsp_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the cache contents, counters and registers.
    bpc_pkg::entry_t model_ways [0:SLOTS-1];
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] store_total;
    logic [22:0] mate_reg;
    logic [7:0] age_reg;

    bpc_pkg::req_t request_backlog [$];
    bpc_pkg::rsp_t expected_replies [$];
    logic [31:0] tag_pool [0:5];
    int mismatches = 0;
    int send_hold = 0;
    int ready_hold = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    bucketed_position_cache #(
        .BUCKET_COUNT(BUCKETS),
        .WAYS(WAYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Empty every way and zero the counters, as reset and clear do.
    function automatic void wipe_model();
        int i;
        for (i = 0; i < SLOTS; i++)
            model_ways[i] = '0;
        hit_total = '0;
        miss_total = '0;
        store_total = '0;
    endfunction

    // Apply one request to the shadow cache and return the reply it should give.
    function automatic bpc_pkg::rsp_t predict_reply(input bpc_pkg::req_t rq);
        bpc_pkg::rsp_t r;
        bpc_pkg::entry_t e;
        logic [31:0] tag;
        int base;
        int w;
        int target;
        int shallow;
        longint shallow_depth;
        longint s;
        bit found;
        r = '0;
        found = 1'b0;
        tag = rq.key[63:32];
        base = int'(rq.key[9:0]) * WAYS;
        case (rq.req_type)
            bpc_pkg::REQ_PROBE:
            begin
                for (w = 0; w < WAYS && !found; w++)
                begin
                    if (model_ways[base + w].tag == tag)
                    begin
                        found = 1'b1;
                        e = model_ways[base + w];
                    end
                end
                if (found)
                begin
                    r.hit = 1'b1;
                    r.out_move = e.move;
                    r.out_score = e.score;
                    r.out_depth = e.depth;
                    r.out_flag = e.flag;
                    r.out_age = e.age;
                    hit_total++;
                end
                else
                    miss_total++;
            end
            bpc_pkg::REQ_STORE:
            begin
                // Scores in the upper (lower) mate range gain (lose) ply, then saturate.
                s = rq.score;
                if (s > longint'(mate_reg) - MATE_SPAN)
                    s = s + longint'(rq.ply);
                else if (s < -longint'(mate_reg) + MATE_SPAN)
                    s = s - longint'(rq.ply);
                if (s > SAT_HI)
                    s = SAT_HI;
                if (s < SAT_LO)
                    s = SAT_LO;

                // First matching, empty or stale way; else the shallowest one.
                target = -1;
                shallow = 0;
                shallow_depth = 64'sh7fff_ffff;
                for (w = 0; w < WAYS && target < 0; w++)
                begin
                    e = model_ways[base + w];
                    if (e.tag == tag || e.tag == '0 || e.age != age_reg)
                        target = w;
                    else if (e.depth < shallow_depth)
                    begin
                        shallow_depth = e.depth;
                        shallow = w;
                    end
                end
                if (target < 0)
                    target = shallow;
                e = model_ways[base + target];
                if (e.tag == tag || e.tag == '0 || e.age != age_reg || rq.depth >= e.depth)
                begin
                    e.tag = tag;
                    e.move = rq.move;
                    e.score = s[23:0];
                    e.depth = rq.depth;
                    e.flag = rq.bound_flag;
                    e.age = age_reg;
                    model_ways[base + target] = e;
                    store_total++;
                    r.written = 1'b1;
                end
            end
            bpc_pkg::REQ_CLEAR:
                wipe_model();
            default:
                ;
        endcase
        r.hit_count = hit_total;
        r.miss_count = miss_total;
        r.store_count = store_total;
        return r;
    endfunction

    function automatic bpc_pkg::req_t make_req(input logic [1:0] kind, input logic [63:0] key,
                                               input logic [15:0] move, input logic [23:0] score,
                                               input logic [15:0] depth, input logic [1:0] flag,
                                               input logic [7:0] ply);
        bpc_pkg::req_t rq;
        rq.req_type = kind;
        rq.key = key;
        rq.move = move;
        rq.score = score;
        rq.depth = depth;
        rq.bound_flag = flag;
        rq.ply = ply;
        return rq;
    endfunction

    // Random request aimed at a few busy buckets and a small pool of tags.
    function automatic bpc_pkg::req_t random_request();
        bpc_pkg::req_t rq;
        int unsigned roll;
        logic [9:0] bucket;
        logic [31:0] tag;
        longint s;
        roll = $urandom_range(0, 999);
        if (roll < 10)
            rq.req_type = bpc_pkg::REQ_CLEAR;
        else if (roll < 40)
            rq.req_type = REQ_UNUSED;
        else if (roll < 480)
            rq.req_type = bpc_pkg::REQ_PROBE;
        else
            rq.req_type = bpc_pkg::REQ_STORE;

        if ($urandom_range(0, 9) < 8)
            bucket = 10'($urandom_range(0, 3) * 341);
        else
            bucket = 10'($urandom);
        roll = $urandom_range(0, 19);
        if (roll == 0)
            tag = '0;
        else if (roll == 1)
            tag = $urandom;
        else
            tag = tag_pool[roll % 6];
        rq.key = {tag, 22'($urandom), bucket};

        // Scores are random or cluster around zero, both mate-window edges and the saturation limits.
        case ($urandom_range(0, 5))
            0: s = longint'($signed(24'($urandom)));
            1: s = longint'(mate_reg) - MATE_SPAN + int'($urandom_range(0, 4)) - 2;
            2: s = -longint'(mate_reg) + MATE_SPAN + int'($urandom_range(0, 4)) - 2;
            3: s = SAT_HI - int'($urandom_range(0, 300));
            4: s = SAT_LO + int'($urandom_range(0, 300));
            default: s = int'($urandom_range(0, 400)) - 200;
        endcase
        rq.score = s[23:0];
        if ($urandom_range(0, 9) == 0)
            rq.depth = 16'($urandom);
        else
            rq.depth = 16'(int'($urandom_range(0, 16)) - 4);
        rq.move = 16'($urandom);
        rq.bound_flag = 2'($urandom);
        rq.ply = 8'($urandom);
        return rq;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int next_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input bpc_pkg::rsp_t got);
        bpc_pkg::rsp_t want;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: reply expected none, actual %0h", $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_replies.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("written", want.written, got.written);
            compare_field("out_move", want.out_move, got.out_move);
            compare_field("out_score", want.out_score, got.out_score);
            compare_field("out_depth", want.out_depth, got.out_depth);
            compare_field("out_flag", want.out_flag, got.out_flag);
            compare_field("out_age", want.out_age, got.out_age);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("miss_count", want.miss_count, got.miss_count);
            compare_field("store_count", want.store_count, got.store_count);
        end
    endtask

    // One register write; the shadow register follows at the transaction.
    task automatic write_cfg(input bpc_pkg::cfg_reg_t idx, input logic [22:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == bpc_pkg::CFG_MATE_SCORE)
            mate_reg = value;
        else
            age_reg = value[7:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_valid || expected_replies.size() != 0);
    endtask

    // Request driver: predicts each transaction as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_hold = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_replies.push_back(predict_reply(req_data));
            if (!req_valid || req_ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    req_valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    req_data <= request_backlog.pop_front();
                    req_valid <= 1'b1;
                    send_hold = next_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Reply monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_reply(rsp_data);
            if (ready_hold > 0)
            begin
                ready_hold--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                ready_hold = next_gap();
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus sequence: reset, directed requests, then random phases.
    initial
    begin
        int phase;
        int n;
        logic [22:0] mate;
        logic [7:0] age;
        wipe_model();
        mate_reg = 23'd30000;
        age_reg = 8'd0;
        tag_pool[0] = 32'hffff_ffff;
        for (n = 1; n < 6; n++)
            tag_pool[n] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on bucket 5 and the extreme keys, with reset register values.
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'hdead_beef_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0001_0000_0005,
                                           16'hffff, 24'h7f_ffff, 16'h7fff, 2'd3, 8'd255));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h8000_0000_0000_0005,
                                           16'h0000, 24'h80_0000, 16'h8000, 2'd0, 8'd255));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0000_0001_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h8000_0000_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0000_0000_0005,
                                           16'h1234, 24'd29500, 16'd5, 2'd1, 8'd10));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0000_0000_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0003_0000_0005,
                                           16'h0abc, -24'sd29500, 16'd3, 2'd2, 8'd10));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0004_0000_0005,
                                           16'h0444, 24'd0, 16'd7, 2'd1, 8'd200));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0005_0000_0005,
                                           16'h0555, 24'd100, 16'd2, 2'd2, 8'd1));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0006_0000_0005,
                                           16'h0666, 24'd50, 16'd1, 2'd3, 8'd1));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0006_0000_0005,
                                           16'h0667, 24'd51, 16'd2, 2'd3, 8'd1));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0001_0000_0005,
                                           16'h0111, 24'd29000, 16'hfffb, 2'd0, 8'd7));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0000_0001_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(REQ_UNUSED, 64'h0000_0001_0000_0005, 16'hffff,
                                           24'h7f_ffff, 16'h7fff, 2'd3, 8'd255));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'hffff_ffff_ffff_ffff,
                                           16'hffff, 24'd0, 16'd0, 2'd1, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'hffff_ffff_ffff_ffff,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0000_0006_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_CLEAR, 64'h0,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'h0000_0001_0000_0005,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_PROBE, 64'hffff_ffff_ffff_ffff,
                                           16'h0, 24'h0, 16'h0, 2'd0, 8'd0));
        request_backlog.push_back(make_req(bpc_pkg::REQ_STORE, 64'h0000_0001_0000_0005,
                                           16'h5a5a, -24'sd29500, 16'd4, 2'd2, 8'd33));
        wait_drained();

        // Random phases, each under its own register setting.
        for (phase = 1; phase <= PHASES; phase++)
        begin
            case (phase)
                1: begin mate = 23'd0; age = 8'hff; end
                2: begin mate = 23'h7f_ffff; age = 8'h00; end
                3: begin mate = 23'd30000; age = 8'h01; end
                4: begin mate = 23'd1000; age = 8'hff; end
                5: begin mate = 23'($urandom); age = 8'($urandom); end
                6: begin mate = 23'($urandom_range(0, 3000)); age = age_reg + 8'd1; end
                7: begin mate = 23'd30000; age = 8'($urandom); end
                default: begin mate = 23'($urandom_range(0, 40000)); age = 8'($urandom); end
            endcase
            write_cfg(bpc_pkg::CFG_MATE_SCORE, mate);
            write_cfg(bpc_pkg::CFG_CURRENT_AGE, {15'd0, age});
            calm = (phase == 5);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                request_backlog.push_back(random_request());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
